// ===== sv/sha256d_pkg.sv =====
package sha256d_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned NumRegs   = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [CfgIdxW-1:0] RegMid01  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMid23  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMid45  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMid67  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTail01 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTail2  = 3'd5;

  typedef logic [31:0] word_t;
  typedef word_t [7:0]  state_t;
  typedef word_t [15:0] sched_t;

  typedef struct packed {
    state_t chain;
    state_t v;
    sched_t w;
    word_t  nonce;
  } stage_t;

  localparam word_t [63:0] KROUND = '{
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  localparam state_t HSTART = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== sv/sha256d_round.sv =====
module sha256d_round
  import sha256d_pkg::*;
#(
  parameter int unsigned RoundIdx = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_vld,
  input  stage_t in_stage,
  output logic   out_vld,
  output stage_t out_stage
);

  localparam logic [5:0] RIdx = 6'(RoundIdx);

  logic   vld_r;
  stage_t stage_r;
  stage_t stage_nxt;
  word_t  t1, t2, wn, s0, s1;
  state_t v;

  always_comb begin
    v  = in_stage.v;
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + KROUND[RIdx] + in_stage.w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
    s0 = rotr(in_stage.w[1], 7) ^ rotr(in_stage.w[1], 18) ^ (in_stage.w[1] >> 3);
    s1 = rotr(in_stage.w[14], 17) ^ rotr(in_stage.w[14], 19) ^ (in_stage.w[14] >> 10);
    wn = in_stage.w[0] + s0 + in_stage.w[9] + s1;
    stage_nxt = in_stage;
    stage_nxt.v = {v[6], v[5], v[4], v[3] + t1, v[2], v[1], v[0], t1 + t2};
    stage_nxt.w = {wn, in_stage.w[15:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_vld   = vld_r;
  assign out_stage = stage_r;

endmodule

// ===== sv/sha256d_compress.sv =====
module sha256d_compress
  import sha256d_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_vld,
  input  stage_t in_stage,
  output logic   out_vld,
  output stage_t out_stage
);

  logic   [NumRounds:0] vld;
  stage_t [NumRounds:0] stg;

  assign vld[0] = in_vld;
  assign stg[0] = in_stage;

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    sha256d_round #(.RoundIdx(r)) u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (vld[r]),
      .in_stage (stg[r]),
      .out_vld  (vld[r+1]),
      .out_stage(stg[r+1])
    );
  end

  always_comb begin
    out_stage = stg[NumRounds];
    for (int i = 0; i < 8; i++) begin
      out_stage.v[i] = stg[NumRounds].chain[i] + stg[NumRounds].v[i];
    end
  end
  assign out_vld = vld[NumRounds];

endmodule

// ===== sv/double_sha256_nonce_hash_top.sv =====
// Pipeline: two compressions of 64 rounds each, one register per round, plus an
// output register between the second compression and the result.
// Throughput: one nonce per cycle while not stalled by out_ready; one register stage per SHA-256 round.
// Reset: synchronous, active low; clears valid bits and configuration to zero.
module double_sha256_nonce_hash_top
  import sha256d_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_nonce,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_candidate,
  output logic [31:0]         out_nonce_echo,
  output logic [63:0]         out_digest_words_0_1,
  output logic [63:0]         out_digest_words_2_3,
  output logic [63:0]         out_digest_words_4_5,
  output logic [63:0]         out_digest_words_6_7
);

  logic [63:0] mid_r [4];
  logic [63:0] tail01_r;
  word_t       tail2_r;
  logic        en;
  stage_t      s1_in, s1_out, s2_in, s2_out;
  logic        v1_out, v2_out;
  logic        out_valid_r;
  stage_t      out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) mid_r[i] <= '0;
      tail01_r <= '0;
      tail2_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegMid01:  mid_r[0] <= cfg_data;
        RegMid23:  mid_r[1] <= cfg_data;
        RegMid45:  mid_r[2] <= cfg_data;
        RegMid67:  mid_r[3] <= cfg_data;
        RegTail01: tail01_r <= cfg_data;
        RegTail2:  tail2_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    s1_in = '0;
    for (int i = 0; i < 4; i++) begin
      s1_in.chain[2*i]   = mid_r[i][63:32];
      s1_in.chain[2*i+1] = mid_r[i][31:0];
    end
    s1_in.v     = s1_in.chain;
    s1_in.w[0]  = tail01_r[63:32];
    s1_in.w[1]  = tail01_r[31:0];
    s1_in.w[2]  = tail2_r;
    s1_in.w[3]  = in_nonce;
    s1_in.w[4]  = 32'h80000000;
    s1_in.w[15] = 32'h00000280;
    s1_in.nonce = in_nonce;

    s2_in = '0;
    s2_in.chain = HSTART;
    s2_in.v     = HSTART;
    for (int i = 0; i < 8; i++) s2_in.w[i] = s1_out.v[i];
    s2_in.w[8]  = 32'h80000000;
    s2_in.w[15] = 32'h00000100;
    s2_in.nonce = s1_out.nonce;
  end

  sha256d_compress u_first (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_valid), .in_stage(s1_in),
    .out_vld(v1_out), .out_stage(s1_out)
  );

  sha256d_compress u_second (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(v1_out), .in_stage(s2_in),
    .out_vld(v2_out), .out_stage(s2_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v2_out;
    end
    if (en) begin
      out_r <= s2_out;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_candidate        = (out_r.v[7] == '0);
  assign out_nonce_echo       = out_r.nonce;
  assign out_digest_words_0_1 = {out_r.v[0], out_r.v[1]};
  assign out_digest_words_2_3 = {out_r.v[2], out_r.v[3]};
  assign out_digest_words_4_5 = {out_r.v[4], out_r.v[5]};
  assign out_digest_words_6_7 = {out_r.v[6], out_r.v[7]};

endmodule
